// ----- hw/rtl/csm_pkg.sv -----
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types and constants of the counting semaphore manager.
// ----------------------------------------------------------------------------
package csm_pkg;
	localparam int NUM_RESOURCES = 4;
	localparam int NUM_PROCESSES = 16;
	localparam int QUEUE_DEPTH = 16;
	localparam int RES_W = $clog2(NUM_RESOURCES);
	localparam int PID_W = $clog2(NUM_PROCESSES);
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = QPTR_W + 1;
	localparam int CNT_W = 10;
	localparam int HELD_W = 8;
	localparam int WAKE_W = 4;
	localparam int COUNT_MAX = 255;
	localparam int HELD_MAX = 255;
	localparam int WAKE_BUDGET = 15;

	typedef enum logic [1:0] {
		CMD_ACQUIRE = 2'd0,
		CMD_GIVE    = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		OUT_CONTINUE = 3'd0,
		OUT_BLOCKED  = 3'd1,
		OUT_WOKEN    = 3'd2,
		OUT_RELEASED = 3'd3,
		OUT_ERROR    = 3'd4
	} outcome_t;

	typedef enum logic [2:0] {
		REG_ACTIVE = 3'd0,
		REG_INIT0  = 3'd1,
		REG_INIT1  = 3'd2,
		REG_INIT2  = 3'd3,
		REG_INIT3  = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_RD,
		ST_ACQ,
		ST_GIVE,
		ST_GIVE2,
		ST_REL_RD,
		ST_REL_CALC,
		ST_REL_FRD,
		ST_REL_POP,
		ST_REL_DONE
	} state_t;
endpackage

// ----- hw/rtl/counting_semaphore_manager_unit.sv -----
// ----------------------------------------------------------------------------
// counting_semaphore_manager_unit
// Counting semaphores with per-resource FIFO wait queues and held tables.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid / in_stall) carries cmd, pid, resource. in_stall is
//   high while a command is in work; one command is handled at a time.
//   output channel (out_valid / out_stall) carries one result per transaction
//   through an output register; last marks the final result of a command.
//   acquire: ST_RD, ST_ACQ; give: ST_RD, ST_GIVE (ST_GIVE2 on a wake); a bad
//   index: ST_ERR. release walks the resources in turn: ST_REL_RD, ST_REL_CALC
//   each, ST_REL_FRD and ST_REL_POP per woken waiter, then ST_REL_DONE for the
//   done result. the steps are set by the single read port of the held table
//   and wait queue memories and the one count adder shared by all commands.
//   cmd 3 is dropped with no result.
//   a stalled receiver holds the sequencer in its emitting state; nothing
//   changes until the result register frees up.
//   reset sets every count to 1, clears the held
//   table through per-entry valid bits and empties all queues; no sweep.
//   writing an initial count register reloads that count and empties its queue.
// ----------------------------------------------------------------------------
module counting_semaphore_manager_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [7:0]  wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [3:0]  pid,
	input  logic [1:0]  resource,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  outcome,
	output logic [3:0]  who_pid,
	output logic [1:0]  which_resource,
	output logic signed [8:0] count_after,
	output logic        last
);
	import csm_pkg::*;

	localparam int MEM_DEPTH = NUM_PROCESSES * NUM_RESOURCES;
	localparam int HADDR_W = PID_W + RES_W;
	localparam int FADDR_W = RES_W + QPTR_W;

	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [PID_W-1:0] pid_q;
	logic [RES_W-1:0] cur_q;
	logic [WAKE_W-1:0] n_q, wk_q;

	logic [2:0] active_q;
	logic signed [CNT_W-1:0] count_q [NUM_RESOURCES];
	logic [QPTR_W-1:0] head_q [NUM_RESOURCES];
	logic [QPTR_W-1:0] tail_q [NUM_RESOURCES];
	logic [FILL_W-1:0] fill_q [NUM_RESOURCES];

	logic [HELD_W-1:0] held_mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] held_vld_q;
	logic [HELD_W-1:0] held_rd_s1;
	logic [PID_W-1:0] fifo_mem [MEM_DEPTH];
	logic [PID_W-1:0] fifo_rd_s1;

	logic [HADDR_W-1:0] held_addr;
	logic [FADDR_W-1:0] fifo_addr;
	logic [HELD_W-1:0] held_val, held_wdata, back;
	logic held_we, fifo_we;
	logic [FILL_W-1:0] fill_cur;
	logic [HELD_W-1:0] want;
	logic [WAKE_W-1:0] budget, woken;
	logic signed [CNT_W:0] delta, sum;
	logic signed [CNT_W-1:0] count_cur, count_new;
	logic [2:0] limit;
	logic bad_res, acq_block, acq_full, give_wake, cur_last;
	logic can_emit, emit;
	logic [2:0] e_outcome;
	logic [PID_W-1:0] e_who;
	logic [RES_W-1:0] e_res;
	logic signed [CNT_W-1:0] e_count;
	logic e_last;
	logic in_acc;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign can_emit = !out_valid || !out_stall;

	assign limit = (active_q > 3'(NUM_RESOURCES)) ? 3'(NUM_RESOURCES) : active_q;
	assign bad_res = ({1'b0, resource} >= limit);

	assign held_addr = {pid_q, cur_q};
	assign fifo_addr = {cur_q, head_q[cur_q]};
	assign held_val = held_vld_q[held_addr] ? held_rd_s1 : '0;
	assign fill_cur = fill_q[cur_q];
	assign count_cur = count_q[cur_q];
	assign cur_last = (cur_q == RES_W'(NUM_RESOURCES - 1));

	// release: wake min(held, waiters) within what is left of the result budget
	assign want = (held_val < HELD_W'(fill_cur)) ? held_val : HELD_W'(fill_cur);
	assign budget = WAKE_W'(WAKE_BUDGET) - n_q;
	assign woken = (want < HELD_W'(budget)) ? want[WAKE_W-1:0] : budget;
	assign back = (HELD_W'(woken) == want) ? held_val : HELD_W'(woken);

	// shared count adder
	always_comb begin
		case (state_q)
			ST_ACQ:      delta = -(CNT_W+1)'(1);
			ST_GIVE:     delta = (CNT_W+1)'(1);
			ST_REL_CALC: delta = (CNT_W+1)'(back);
			default:     delta = '0;
		endcase
	end
	assign sum = {count_cur[CNT_W-1], count_cur} + delta;
	assign count_new = (sum > (CNT_W+1)'(COUNT_MAX)) ? CNT_W'(COUNT_MAX) : sum[CNT_W-1:0];

	assign acq_block = count_cur[CNT_W-1] || (count_cur == '0);
	assign acq_full = (fill_cur >= FILL_W'(QUEUE_DEPTH));
	assign give_wake = (count_new[CNT_W-1] || (count_new == '0)) && (fill_cur != '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (cmd == CMD_NONE) state_d = ST_IDLE;
					else if (cmd == CMD_RELEASE) state_d = ST_REL_RD;
					else if (bad_res) state_d = ST_ERR;
					else state_d = ST_RD;
				end
			end
			ST_RD: state_d = (cmd_q == CMD_ACQUIRE) ? ST_ACQ : ST_GIVE;
			ST_ERR, ST_ACQ, ST_GIVE2, ST_REL_DONE: begin
				if (can_emit) state_d = ST_IDLE;
			end
			ST_GIVE: begin
				if (can_emit) state_d = give_wake ? ST_GIVE2 : ST_IDLE;
			end
			ST_REL_RD: state_d = ST_REL_CALC;
			ST_REL_CALC: begin
				if (woken != '0) state_d = ST_REL_FRD;
				else state_d = cur_last ? ST_REL_DONE : ST_REL_RD;
			end
			ST_REL_FRD: state_d = ST_REL_POP;
			ST_REL_POP: begin
				if (can_emit) begin
					if (wk_q == WAKE_W'(1)) state_d = cur_last ? ST_REL_DONE : ST_REL_RD;
					else state_d = ST_REL_FRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		e_outcome = OUT_CONTINUE;
		e_who = pid_q;
		e_res = cur_q;
		e_count = count_new;
		e_last = 1'b1;
		case (state_q)
			ST_ERR: begin
				emit = 1'b1;
				e_outcome = OUT_ERROR;
				e_count = '0;
			end
			ST_ACQ: begin
				emit = 1'b1;
				if (acq_block && acq_full) begin
					e_outcome = OUT_ERROR;
					e_count = count_cur;
				end else begin
					e_outcome = count_new[CNT_W-1] ? OUT_BLOCKED : OUT_CONTINUE;
				end
			end
			ST_GIVE: begin
				emit = 1'b1;
				if (give_wake) begin
					e_outcome = OUT_WOKEN;
					e_who = fifo_rd_s1;
					e_last = 1'b0;
				end
			end
			ST_GIVE2: begin
				emit = 1'b1;
				e_count = count_cur;
			end
			ST_REL_POP: begin
				emit = 1'b1;
				e_outcome = OUT_WOKEN;
				e_who = fifo_rd_s1;
				e_count = count_cur;
				e_last = 1'b0;
			end
			ST_REL_DONE: begin
				emit = 1'b1;
				e_outcome = OUT_RELEASED;
				e_res = '0;
				e_count = '0;
			end
			default: emit = 1'b0;
		endcase
	end

	always_comb begin
		held_we = 1'b0;
		held_wdata = held_val;
		fifo_we = (state_q == ST_ACQ) && can_emit && acq_block && !acq_full;
		case (state_q)
			ST_ACQ: begin
				held_we = can_emit && !(acq_block && acq_full);
				held_wdata = (held_val == HELD_W'(HELD_MAX)) ? held_val : held_val + 1'b1;
			end
			ST_GIVE: begin
				held_we = can_emit;
				held_wdata = (held_val != '0) ? held_val - 1'b1 : held_val;
			end
			ST_REL_CALC: begin
				held_we = 1'b1;
				held_wdata = held_val - back;
			end
			default: held_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (held_we) held_mem[held_addr] <= held_wdata;
		held_rd_s1 <= held_mem[held_addr];
		if (fifo_we) fifo_mem[{cur_q, tail_q[cur_q]}] <= pid_q;
		fifo_rd_s1 <= fifo_mem[fifo_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q <= CMD_NONE;
			pid_q <= '0;
			cur_q <= '0;
			n_q <= '0;
			wk_q <= '0;
			active_q <= 3'd4;
			held_vld_q <= '0;
			for (int r = 0; r < NUM_RESOURCES; r++) begin
				count_q[r] <= CNT_W'(1);
				head_q[r] <= '0;
				tail_q[r] <= '0;
				fill_q[r] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (held_we) held_vld_q[held_addr] <= 1'b1;
			if (wr_en) begin
				case (reg_idx_t'(wr_index))
					REG_ACTIVE: active_q <= wr_data[2:0];
					REG_INIT0, REG_INIT1, REG_INIT2, REG_INIT3: begin
						count_q[RES_W'(wr_index - 3'd1)] <= CNT_W'(wr_data);
						head_q[RES_W'(wr_index - 3'd1)] <= '0;
						tail_q[RES_W'(wr_index - 3'd1)] <= '0;
						fill_q[RES_W'(wr_index - 3'd1)] <= '0;
					end
					default: active_q <= active_q;
				endcase
			end
			if (in_acc) begin
				cmd_q <= cmd_t'(cmd);
				pid_q <= pid;
				cur_q <= (cmd == CMD_RELEASE) ? '0 : resource;
				n_q <= '0;
			end
			case (state_q)
				ST_ACQ: begin
					if (can_emit && !(acq_block && acq_full)) begin
						count_q[cur_q] <= count_new;
						if (acq_block) begin
							tail_q[cur_q] <= tail_q[cur_q] + 1'b1;
							fill_q[cur_q] <= fill_cur + 1'b1;
						end
					end
				end
				ST_GIVE: begin
					if (can_emit) begin
						count_q[cur_q] <= count_new;
						if (give_wake) begin
							head_q[cur_q] <= head_q[cur_q] + 1'b1;
							fill_q[cur_q] <= fill_cur - 1'b1;
						end
					end
				end
				ST_REL_CALC: begin
					count_q[cur_q] <= count_new;
					wk_q <= woken;
					if (woken == '0 && !cur_last) cur_q <= cur_q + 1'b1;
				end
				ST_REL_POP: begin
					if (can_emit) begin
						head_q[cur_q] <= head_q[cur_q] + 1'b1;
						fill_q[cur_q] <= fill_cur - 1'b1;
						wk_q <= wk_q - 1'b1;
						n_q <= n_q + 1'b1;
						if (wk_q == WAKE_W'(1) && !cur_last) cur_q <= cur_q + 1'b1;
					end
				end
				default: wk_q <= wk_q;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit && can_emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && can_emit) begin
			outcome <= e_outcome;
			who_pid <= e_who;
			which_resource <= e_res;
			count_after <= e_count[8:0];
			last <= e_last;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[cur_q] <= FILL_W'(QUEUE_DEPTH))
		else $error("wait queue fill above depth");
	a_idle_no_wakes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (wk_q == '0))
		else $error("pending wakes left at idle");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[cur_q] <= CNT_W'(COUNT_MAX))
		else $error("count above saturation limit");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !can_emit) |=> (state_q == $past(state_q)))
		else $error("sequencer moved while result blocked");
endmodule
